// File: design/olasd_pkg.sv
// ----------------------------------------------------------------------------
// olasd_pkg
// Shared types, codes and sizes for the ordered list unit.
// ----------------------------------------------------------------------------
package olasd_pkg;

  // List capacity and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted input item
    logic exec;   // run the operation and load the result register
  } olasd_cmd_t;

endpackage

// File: design/olasd_ctrl.sv
// ----------------------------------------------------------------------------
// olasd_ctrl
// Controller: sequences accept and execute, owns the handshake flags.
// ----------------------------------------------------------------------------
module olasd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output olasd_pkg::olasd_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result register may be loaded when empty or drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.exec  = (state_r == S_EXEC) && out_free;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and result-valid flag
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/olasd_dp.sv
// ----------------------------------------------------------------------------
// olasd_dp
// Datapath: entry registers, parallel compare, shift-down delete, result reg.
// ----------------------------------------------------------------------------
module olasd_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  olasd_pkg::olasd_cmd_t cmd,
  input  olasd_pkg::in_item_t   in_item,
  output olasd_pkg::out_item_t  out_item
);

  logic [1:0]                   op_r;
  logic [31:0]                  val_r;
  logic [31:0]                  entries_r [olasd_pkg::DEPTH];
  logic [olasd_pkg::CNT_W-1:0]  count_r, count_nxt;
  olasd_pkg::out_item_t         result_r, result_nxt;

  logic [olasd_pkg::DEPTH-1:0]  match;
  logic                         found;
  logic [olasd_pkg::IDX_W-1:0]  hit_idx;
  logic                         not_full;
  logic                         do_append;
  logic                         do_delete;

  // Compare every valid entry against the operand
  always_comb begin
    for (int i = 0; i < olasd_pkg::DEPTH; i++) begin
      match[i] = (olasd_pkg::CNT_W'(i) < count_r) && (entries_r[i] == val_r);
    end
  end

  // Pick the lowest matching position
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = olasd_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        found   = 1'b1;
        hit_idx = olasd_pkg::IDX_W'(i);
      end
    end
  end

  assign not_full  = (count_r < olasd_pkg::CNT_W'(olasd_pkg::DEPTH));
  assign do_append = (op_r == olasd_pkg::FUNC_APPEND) && not_full;
  assign do_delete = (op_r == olasd_pkg::FUNC_DELETE) && found;

  // Form the result and next count
  always_comb begin
    count_nxt              = count_r;
    result_nxt.status      = olasd_pkg::STAT_DONE;
    result_nxt.position    = '0;
    case (op_r)
      olasd_pkg::FUNC_APPEND: begin
        if (not_full) begin
          result_nxt.position = 4'(count_r);
          count_nxt           = count_r + 1'b1;
        end else begin
          result_nxt.status = olasd_pkg::STAT_FULL;
        end
      end
      olasd_pkg::FUNC_SEARCH: begin
        if (found) begin
          result_nxt.position = 4'(hit_idx);
        end else begin
          result_nxt.status = olasd_pkg::STAT_MISS;
        end
      end
      olasd_pkg::FUNC_DELETE: begin
        if (found) begin
          result_nxt.position = 4'(hit_idx);
          count_nxt           = count_r - 1'b1;
        end else begin
          result_nxt.status = olasd_pkg::STAT_MISS;
        end
      end
      default: begin
      end
    endcase
    result_nxt.entry_count = 5'(count_nxt);
  end

  // Capture the accepted operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_item.func;
      val_r <= in_item.value;
    end
  end

  // Update entries: append at tail, or shift later entries down on delete
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_append) begin
        entries_r[count_r[olasd_pkg::IDX_W-1:0]] <= val_r;
      end
      if (do_delete) begin
        for (int i = 0; i < olasd_pkg::DEPTH - 1; i++) begin
          if (olasd_pkg::IDX_W'(i) >= hit_idx) begin
            entries_r[i] <= entries_r[i+1];
          end
        end
      end
    end
  end

  // Hold count and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_r <= result_nxt;
    end
  end

  assign out_item = result_r;

endmodule

// File: design/ordered_list_append_search_delete_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_append_search_delete_unit
// Bounded list of 32-bit values in insertion order: append, search, delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_item carries an operation code and
//   a value. Each transfer yields exactly one result transfer on out_valid /
//   out_stall / out_item with status, position and the entry count after
//   the operation.
//   Each item is captured into the operand registers, then executed once the
//   output register is free; no new item is taken until then. Execution
//   compares all 16 entries in parallel, and a delete shifts the later
//   entries down in the same cycle.
//   A finished result sits in an output register, so the next item is taken
//   while it waits. If the receiver stalls, execution of the following item
//   holds until the output register frees up; in_stall stays high meanwhile.
//   Reset empties the list (count zero); entry storage is not cleared and
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_append_search_delete_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  olasd_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output olasd_pkg::out_item_t out_item
);

  olasd_pkg::olasd_cmd_t cmd;

  // Sequence the handshakes
  olasd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Store entries and compute results
  olasd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule
